// File: sv/pvt_pkg.sv
// Package for the PSI section version tracker: status codes and default sizes.
// No dependencies; used by every module of the tracker.
package pvt_pkg;

    localparam int MAX_SECTIONS_DEFAULT = 256;
    localparam int CRC_W = 32;

    typedef enum logic [2:0] {
        ST_IGNORE  = 3'd0,
        ST_INITIAL = 3'd1,
        ST_CHANGE  = 3'd2,
        ST_PRESENT = 3'd3,
        ST_APPEND  = 3'd4
    } status_t;

endpackage

// File: sv/psi_section_version_tracker_unit.sv
// Top level of the PSI section version tracker: sequencer, shared comparator,
// seen map, table state and output register. Depends on pvt_pkg and pvt_crc_ram.
//
//  channel | signals                                                 | direction
//  --------+---------------------------------------------------------+----------
//  input   | in_valid, in_stall, table_version, section_index,       | in
//          | last_index, section_crc                                 |
//  output  | out_valid, out_stall, status, complete                  | out
//
// A header is offered as a result after the states S_VER, S_LAST, S_CRC and S_DONE.
// The CRC store read is issued at acceptance, then the shared comparator checks
// version, last number and CRC in turn, and S_DONE loads the output register. A new
// header is accepted only once the previous result is loaded. in_stall is high from
// after acceptance until the result is loaded, and longer while out_stall holds a previous
// result. Reset clears the table state and the seen map at once.
module psi_section_version_tracker_unit #(
    parameter int MAX_SECTIONS = pvt_pkg::MAX_SECTIONS_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [4:0]               table_version,
    input  logic [7:0]               section_index,
    input  logic [7:0]               last_index,
    input  logic [pvt_pkg::CRC_W-1:0] section_crc,
    output logic                     out_valid,
    input  logic                     out_stall,
    output pvt_pkg::status_t         status,
    output logic                     complete
);
    import pvt_pkg::*;

    localparam int IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int CNT_W = $clog2(MAX_SECTIONS + 1);
    localparam logic [8:0] MAX_SEC_9 = 9'(MAX_SECTIONS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_VER,
        S_LAST,
        S_CRC,
        S_DONE
    } state_t;

    state_t              state_reg;
    logic                have_table_reg;
    logic [4:0]          cur_version_reg;
    logic [7:0]          cur_last_reg;
    logic [CNT_W-1:0]    seen_count_reg;
    logic [MAX_SECTIONS-1:0] seen_reg;

    logic [4:0]          ver_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [7:0]          last_reg;
    logic [CRC_W-1:0]    crc_reg;
    logic                ignore_reg;
    logic                ver_eq_reg;
    logic                last_eq_reg;
    status_t             result_reg;

    logic                out_valid_reg;
    status_t             status_reg;
    logic                complete_reg;

    logic [CRC_W-1:0]    cmp_a;
    logic [CRC_W-1:0]    cmp_b;
    logic                cmp_eq;

    logic                accept;
    logic                in_range;
    logic                seen_bit;
    status_t             status_next;
    logic [MAX_SECTIONS-1:0] seen_next;
    logic [CNT_W-1:0]    seen_count_next;
    logic                store_wr;
    logic [CRC_W-1:0]    rd_crc;
    logic                complete_next;
    logic                out_free;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);
    assign in_range = (section_index <= last_index) &&
                      ({1'b0, section_index} < MAX_SEC_9) &&
                      ({1'b0, last_index} < MAX_SEC_9);
    assign seen_bit = seen_reg[idx_reg];
    assign out_free = !out_valid_reg || !out_stall;

    // Shared equality comparator, fed in turn with version, last number and CRC.
    always_comb
    begin
        unique case (state_reg)
            S_VER:
            begin
                cmp_a = CRC_W'(ver_reg);
                cmp_b = CRC_W'(cur_version_reg);
            end
            S_LAST:
            begin
                cmp_a = CRC_W'(last_reg);
                cmp_b = CRC_W'(cur_last_reg);
            end
            S_CRC:
            begin
                cmp_a = crc_reg;
                cmp_b = rd_crc;
            end
            default:
            begin
                cmp_a = '0;
                cmp_b = '0;
            end
        endcase
    end

    assign cmp_eq = (cmp_a == cmp_b);

    always_comb
    begin
        status_next     = ST_APPEND;
        seen_next       = seen_reg;
        seen_count_next = seen_count_reg;
        store_wr        = 1'b0;
        priority if (ignore_reg)
        begin
            status_next = ST_IGNORE;
        end
        else if (!have_table_reg)
        begin
            status_next = ST_INITIAL;
        end
        else if (!ver_eq_reg || !last_eq_reg || (seen_bit && !cmp_eq))
        begin
            status_next = ST_CHANGE;
        end
        else if (seen_bit)
        begin
            status_next = ST_PRESENT;
        end
        else
        begin
            status_next = ST_APPEND;
        end

        if (status_next == ST_INITIAL || status_next == ST_CHANGE)
        begin
            seen_next          = '0;
            seen_next[idx_reg] = 1'b1;
            seen_count_next    = CNT_W'(1);
            store_wr           = 1'b1;
        end
        else if (status_next == ST_APPEND)
        begin
            seen_next[idx_reg] = 1'b1;
            seen_count_next    = seen_count_reg + CNT_W'(1);
            store_wr           = 1'b1;
        end
    end

    assign complete_next = have_table_reg &&
                           (({1'b0, cur_last_reg} + 9'd1) == 9'(seen_count_reg));

    pvt_crc_ram #(
        .DEPTH  (MAX_SECTIONS),
        .ADDR_W (IDX_W)
    ) u_crc_ram (
        .clk     (clk),
        .wr_en   ((state_reg == S_CRC) && store_wr),
        .wr_addr (idx_reg),
        .wr_data (crc_reg),
        .rd_en   (accept),
        .rd_addr (in_range ? section_index[IDX_W-1:0] : '0),
        .rd_data (rd_crc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            have_table_reg  <= 1'b0;
            cur_version_reg <= '0;
            cur_last_reg    <= '0;
            seen_count_reg  <= '0;
            seen_reg        <= '0;
            ver_reg         <= '0;
            idx_reg         <= '0;
            last_reg        <= '0;
            crc_reg         <= '0;
            ignore_reg      <= 1'b0;
            ver_eq_reg      <= 1'b0;
            last_eq_reg     <= 1'b0;
            result_reg      <= ST_IGNORE;
            out_valid_reg   <= 1'b0;
            status_reg      <= ST_IGNORE;
            complete_reg    <= 1'b0;
        end
        else
        begin
            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        ver_reg    <= table_version;
                        idx_reg    <= in_range ? section_index[IDX_W-1:0] : '0;
                        last_reg   <= last_index;
                        crc_reg    <= section_crc;
                        ignore_reg <= !in_range;
                        state_reg  <= S_VER;
                    end
                end
                S_VER:
                begin
                    ver_eq_reg <= cmp_eq;
                    state_reg  <= S_LAST;
                end
                S_LAST:
                begin
                    last_eq_reg <= cmp_eq;
                    state_reg   <= S_CRC;
                end
                S_CRC:
                begin
                    result_reg     <= status_next;
                    seen_reg       <= seen_next;
                    seen_count_reg <= seen_count_next;
                    if (status_next == ST_INITIAL || status_next == ST_CHANGE)
                    begin
                        have_table_reg  <= 1'b1;
                        cur_version_reg <= ver_reg;
                        cur_last_reg    <= last_reg;
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        status_reg    <= result_reg;
                        complete_reg  <= complete_next;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign complete  = complete_reg;

    a_count_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !have_table_reg |-> (seen_count_reg == '0))
        else $error("seen count nonzero without a table");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        have_table_reg |-> (9'(seen_count_reg) <= ({1'b0, cur_last_reg} + 9'd1)))
        else $error("seen count exceeds the section count of the table");

    a_crc_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CRC) |=> (state_reg == S_DONE))
        else $error("decision step not followed by result step");

    a_complete_table: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && complete_reg) |-> have_table_reg)
        else $error("complete reported with no table held");

    a_table_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        have_table_reg |-> ($countones(seen_reg) == 32'(seen_count_reg)))
        else $error("seen map and seen count disagree");

endmodule

// File: sv/pvt_crc_ram.sv
// Single-port-write, single-port-read CRC store with registered read data.
// Depends on pvt_pkg for the CRC word width.
module pvt_crc_ram #(
    parameter int DEPTH  = pvt_pkg::MAX_SECTIONS_DEFAULT,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [ADDR_W-1:0]        wr_addr,
    input  logic [pvt_pkg::CRC_W-1:0] wr_data,
    input  logic                     rd_en,
    input  logic [ADDR_W-1:0]        rd_addr,
    output logic [pvt_pkg::CRC_W-1:0] rd_data
);
    import pvt_pkg::*;

    logic [CRC_W-1:0] mem_reg [DEPTH];
    logic [CRC_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
